// ----- rtl/triangle_tangent_bitangent_assert.svh -----
// Assertion macros shared by the tangent / bitangent checker.
`ifndef TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TANBT_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tanbt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TANBT_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tanbt check failed");

`endif

// ----- rtl/tanbt_pkg.sv -----
// Package: widths, queue entry type and helpers for the tangent / bitangent block.
package tanbt_pkg;

	localparam int COORD_W  = 32;
	localparam int OUT_W    = 16;
	localparam int FRAC     = OUT_W - 2;
	localparam int UNIT     = 1 << FRAC;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int HALF_W   = COORD_W + 1;
	localparam int MUL_W    = HALF_W + 1;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int CROSS_W  = 2 * EDGE_W + 1;
	localparam int MAG_W    = 2 * HALF_W;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int RSH      = 2 * FRAC + 2;
	localparam int NW       = SQ_W + RSH + 6;
	localparam int QW       = FRAC + 1;
	localparam int BIT_W    = $clog2(QW);
	localparam int NAXIS    = 3;
	localparam int NCOMP    = 2 * NAXIS;
	localparam int NCROSS   = NCOMP + 1;
	localparam int COMP_W   = $clog2(NCOMP);
	localparam int CROSS_CW = $clog2(NCROSS);
	localparam int NCOPY    = 3;
	localparam int COPY_W   = $clog2(NCOPY);
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

	typedef logic [EDGE_W-1:0] edge_t;

	// One triangle, reduced to its edges, as it waits between front and back.
	typedef struct packed {
		logic [NAXIS-1:0][EDGE_W-1:0] e1;
		logic [NAXIS-1:0][EDGE_W-1:0] e2;
		edge_t d1u;
		edge_t d1v;
		edge_t d2u;
		edge_t d2v;
	} tri_t;

	// a - b on sign-extended coordinates, exact
	function automatic edge_t edge_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	function automatic logic signed [MUL_W-1:0] mul_sx(edge_t e);
		return {e[EDGE_W-1], e};
	endfunction

endpackage

// ----- rtl/tanbt_vtx_if.sv -----
// Vertex channel: valid / ready plus one vertex position and texture coordinate.
interface tanbt_vtx_if;
	import tanbt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic signed [COORD_W-1:0] tex_u;
	logic signed [COORD_W-1:0] tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ----- rtl/tanbt_res_if.sv -----
// Result channel: valid / ready plus unit tangent, unit bitangent and flags.
interface tanbt_res_if;
	import tanbt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] tangent_x;
	logic signed [OUT_W-1:0] tangent_y;
	logic signed [OUT_W-1:0] tangent_z;
	logic signed [OUT_W-1:0] bitangent_x;
	logic signed [OUT_W-1:0] bitangent_y;
	logic signed [OUT_W-1:0] bitangent_z;
	logic                    degenerate;
	logic                    last_copy;

	modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, degenerate, last_copy, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, degenerate, last_copy, output ready);
endinterface

// ----- rtl/tanbt_front.sv -----
// Front end: holds the first two vertices and turns the third into edge vectors.
module tanbt_front (
	input  logic            clk,
	input  logic            arst_n,
	tanbt_vtx_if.sink       vtx,
	output logic            push_valid,
	input  logic            push_ready,
	output tanbt_pkg::tri_t push_data
);
	import tanbt_pkg::*;

	localparam logic [1:0] PH_V0  = 2'd0;
	localparam logic [1:0] PH_V2  = 2'd2;
	localparam logic [1:0] PH_BAD = 2'd3;

	logic [1:0]                    phase_q;
	logic [1:0]                    phase_eff;
	logic                          third;
	logic                          xfer;
	logic [NAXIS-1:0][COORD_W-1:0] pin;
	logic [NAXIS-1:0][COORD_W-1:0] pos_q [2];
	logic [1:0][COORD_W-1:0]       tex_q [2];

	assign pin       = {vtx.pos_z, vtx.pos_y, vtx.pos_x};
	assign phase_eff = (phase_q == PH_BAD) ? PH_V0 : phase_q;
	assign third     = (phase_eff == PH_V2);
	assign vtx.ready = !third || push_ready;
	assign push_valid = vtx.valid && third;
	assign xfer      = vtx.valid && vtx.ready;

	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			push_data.e1[i] = edge_diff(pos_q[1][i], pos_q[0][i]);
			push_data.e2[i] = edge_diff(pin[i], pos_q[0][i]);
		end
		push_data.d1u = edge_diff(tex_q[1][0], tex_q[0][0]);
		push_data.d1v = edge_diff(tex_q[1][1], tex_q[0][1]);
		push_data.d2u = edge_diff(vtx.tex_u, tex_q[0][0]);
		push_data.d2v = edge_diff(vtx.tex_v, tex_q[0][1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_V0;
		end else if (xfer) begin
			phase_q <= third ? PH_V0 : phase_eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && !third) begin
			pos_q[phase_eff[0]] <= pin;
			tex_q[phase_eff[0]] <= {vtx.tex_v, vtx.tex_u};
		end
	end

endmodule

// ----- rtl/tanbt_fifo.sv -----
// Short queue of triangles between the front end and the arithmetic back end.
module tanbt_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tanbt_pkg::tri_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tanbt_pkg::tri_t pop_data
);
	import tanbt_pkg::*;

	tri_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/tanbt_back.sv -----
// Back end: cross products, squared lengths and bit-serial normalisation on one multiplier.
module tanbt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  tanbt_pkg::tri_t pop_data,
	tanbt_res_if.source     res
);
	import tanbt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CROSS, ST_SQUARE, ST_CHECK, ST_NINIT, ST_NORM_A, ST_NORM_B, ST_EMIT
	} state_t;

	// step codes within a cross product
	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_DIFF   = 3'd2;
	// step codes within a square
	localparam logic [2:0] PH_LL     = 3'd0;
	localparam logic [2:0] PH_HL     = 3'd1;
	localparam logic [2:0] PH_HH     = 3'd2;
	localparam logic [2:0] PH_ADD_HH = 3'd3;
	localparam logic [2:0] PH_STORE  = 3'd4;

	localparam logic [CROSS_CW-1:0] CR_DET  = CROSS_CW'(0);
	localparam logic [CROSS_CW-1:0] CR_T0   = CROSS_CW'(1);
	localparam logic [CROSS_CW-1:0] CR_B0   = CROSS_CW'(1 + NAXIS);
	localparam logic [CROSS_CW-1:0] CR_LAST = CROSS_CW'(NCROSS - 1);

	state_t                     state_q;
	logic [CROSS_CW-1:0]        cr_q;
	logic [2:0]                 ph_q;
	logic [COMP_W-1:0]          j_q;
	logic [BIT_W-1:0]           bit_q;
	logic [COPY_W-1:0]          copy_q;

	tri_t                       tri_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [SQ_W-1:0]            acc_q;
	logic                       det_neg_q;
	logic                       det_zero_q;
	logic                       deg_q;
	logic [MAG_W-1:0]           mag_q [NCOMP];
	logic                       neg_q [NCOMP];
	logic [SQ_W-1:0]            sq_q [NCOMP];
	logic [SQ_W-1:0]            st_q;
	logic [SQ_W-1:0]            sb_q;
	logic [NW-1:0]              p_q;
	logic [NW-1:0]              qs_q;
	logic [NW-1:0]              ss_q;
	logic [NW-1:0]              tmp_q;
	logic [NW-1:0]              r_q;
	logic [QW-1:0]              q_q;
	logic signed [OUT_W-1:0]    res_q [NCOMP];

	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [CROSS_W-1:0]  cross_d;
	logic signed [CROSS_W-1:0]  cross_abs;
	logic                       cross_neg;
	logic                       cross_nz;
	logic [CROSS_CW-1:0]        cr_off;
	logic [COMP_W-1:0]          cmp_idx;
	logic [MAG_W-1:0]           prod_u;
	logic                       deg_now;
	logic [SQ_W-1:0]            s_sel;
	logic [NW-1:0]              cand;
	logic                       take_bit;
	logic [NW-1:0]              qs_upd;
	logic [QW-1:0]              q_new;
	logic signed [OUT_W-1:0]    res_val;

	// operand selection for the shared multiplier
	always_comb begin
		logic [MAG_W-1:0]    mag;
		logic [CROSS_CW-1:0] off;
		logic [1:0]          lane;
		mag   = mag_q[j_q];
		off   = '0;
		lane  = '0;
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SQUARE) begin
			unique case (ph_q)
				PH_LL: begin
					mul_a = {1'b0, mag[HALF_W-1:0]};
					mul_b = {1'b0, mag[HALF_W-1:0]};
				end
				PH_HL: begin
					mul_a = {1'b0, mag[MAG_W-1:HALF_W]};
					mul_b = {1'b0, mag[HALF_W-1:0]};
				end
				default: begin
					mul_a = {1'b0, mag[MAG_W-1:HALF_W]};
					mul_b = {1'b0, mag[MAG_W-1:HALF_W]};
				end
			endcase
		end else begin
			priority if (cr_q == CR_DET) begin
				mul_a = mul_sx((ph_q == PH_FIRST) ? tri_q.d1u : tri_q.d1v);
				mul_b = mul_sx((ph_q == PH_FIRST) ? tri_q.d2v : tri_q.d2u);
			end else if (cr_q < CR_B0) begin
				off  = cr_q - CR_T0;
				lane = off[1:0];
				mul_a = mul_sx((ph_q == PH_FIRST) ? tri_q.e1[lane] : tri_q.e2[lane]);
				mul_b = mul_sx((ph_q == PH_FIRST) ? tri_q.d2v : tri_q.d1v);
			end else begin
				off  = cr_q - CR_B0;
				lane = off[1:0];
				mul_a = mul_sx((ph_q == PH_FIRST) ? tri_q.e2[lane] : tri_q.e1[lane]);
				mul_b = mul_sx((ph_q == PH_FIRST) ? tri_q.d1u : tri_q.d2u);
			end
		end
	end

	always_comb begin
		cross_d   = $signed(acc_q[CROSS_W-1:0]) - $signed(prod_s1[CROSS_W-1:0]);
		cross_neg = cross_d[CROSS_W-1];
		cross_nz  = |cross_d;
		cross_abs = cross_neg ? -cross_d : cross_d;
		cr_off    = cr_q - CR_T0;
		cmp_idx   = cr_off[COMP_W-1:0];
		prod_u    = prod_s1[MAG_W-1:0];
		deg_now   = det_zero_q || (st_q == '0) || (sb_q == '0);
		s_sel     = (j_q < COMP_W'(NAXIS)) ? st_q : sb_q;
		// candidate S*(2q-1)^2 for q with the current bit set, against c^2 scaled
		cand      = tmp_q + ss_q;
		take_bit  = !q_q[QW-1] && (cand <= r_q);
		qs_upd    = take_bit ? qs_q + (ss_q << 1) : qs_q;
		q_new     = take_bit ? (q_q | (QW'(1) << bit_q)) : q_q;
		res_val   = neg_q[j_q] ? -OUT_W'(q_new) : OUT_W'(q_new);
	end

	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cr_q    <= '0;
			ph_q    <= '0;
			j_q     <= '0;
			bit_q   <= '0;
			copy_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_CROSS;
						cr_q    <= CR_DET;
						ph_q    <= PH_FIRST;
					end
				end
				ST_CROSS: begin
					if (ph_q == PH_DIFF) begin
						ph_q <= PH_FIRST;
						if (cr_q == CR_LAST) begin
							state_q <= ST_SQUARE;
							j_q     <= '0;
						end else begin
							cr_q <= cr_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_SQUARE: begin
					if (ph_q == PH_STORE) begin
						ph_q <= PH_LL;
						if (j_q == COMP_W'(NCOMP - 1)) begin
							state_q <= ST_CHECK;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_CHECK: begin
					j_q    <= '0;
					copy_q <= '0;
					state_q <= deg_now ? ST_EMIT : ST_NINIT;
				end
				ST_NINIT: begin
					bit_q   <= BIT_W'(FRAC);
					state_q <= ST_NORM_A;
				end
				ST_NORM_A: begin
					state_q <= ST_NORM_B;
				end
				ST_NORM_B: begin
					if (bit_q == '0) begin
						if (j_q == COMP_W'(NCOMP - 1)) begin
							state_q <= ST_EMIT;
							copy_q  <= '0;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_NINIT;
						end
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= ST_NORM_A;
					end
				end
				ST_EMIT: begin
					if (res.ready) begin
						if (copy_q == COPY_W'(NCOPY - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							copy_q <= copy_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					tri_q <= pop_data;
				end
				st_q <= '0;
				sb_q <= '0;
			end
			ST_CROSS: begin
				if (ph_q == PH_SECOND) begin
					acc_q <= SQ_W'(prod_s1);
				end else if (ph_q == PH_DIFF) begin
					if (cr_q == CR_DET) begin
						det_neg_q  <= cross_neg;
						det_zero_q <= !cross_nz;
					end else begin
						mag_q[cmp_idx] <= cross_abs[MAG_W-1:0];
						// a negative determinant flips both vectors
						neg_q[cmp_idx] <= (cross_neg ^ det_neg_q) && cross_nz;
					end
				end
			end
			ST_SQUARE: begin
				unique case (ph_q)
					PH_HL:     acc_q <= SQ_W'(prod_u);
					PH_HH:     acc_q <= acc_q + (SQ_W'(prod_u) << (HALF_W + 1));
					PH_ADD_HH: acc_q <= acc_q + (SQ_W'(prod_u) << (2 * HALF_W));
					PH_STORE: begin
						sq_q[j_q] <= acc_q;
						if (j_q < COMP_W'(NAXIS)) begin
							st_q <= st_q + acc_q;
						end else begin
							sb_q <= sb_q + acc_q;
						end
					end
					default: ;
				endcase
			end
			ST_CHECK: begin
				deg_q <= deg_now;
				if (deg_now) begin
					for (int i = 0; i < NCOMP; i++) begin
						res_q[i] <= '0;
					end
				end
			end
			ST_NINIT: begin
				// q = 0: P = S*1, Qs = S*(-1) << (FRAC+2), Ss = S << (2*FRAC+2)
				p_q  <= NW'(s_sel);
				qs_q <= -(NW'(s_sel) << (FRAC + 2));
				ss_q <= NW'(s_sel) << RSH;
				r_q  <= NW'(sq_q[j_q]) << RSH;
				q_q  <= '0;
			end
			ST_NORM_A: begin
				tmp_q <= p_q + qs_q;
			end
			ST_NORM_B: begin
				if (take_bit) begin
					p_q <= cand;
				end
				qs_q <= NW'($signed(qs_upd) >>> 1);
				ss_q <= ss_q >> 2;
				q_q  <= q_new;
				if (bit_q == '0) begin
					res_q[j_q] <= res_val;
				end
			end
			default: ;
		endcase
	end

	assign res.valid       = (state_q == ST_EMIT);
	assign res.tangent_x   = res_q[0];
	assign res.tangent_y   = res_q[1];
	assign res.tangent_z   = res_q[2];
	assign res.bitangent_x = res_q[3];
	assign res.bitangent_y = res_q[4];
	assign res.bitangent_z = res_q[5];
	assign res.degenerate  = deg_q;
	assign res.last_copy   = (copy_q == COPY_W'(NCOPY - 1));

endmodule

// ----- rtl/triangle_tangent_bitangent.sv -----
// Top level of the triangle tangent / bitangent unit.
// Channel vtx takes one vertex per transfer: position and texture coordinate in
// signed Q16.16. Every third vertex closes a triangle. Channel res gives three
// transfers per triangle with the unit tangent and bitangent in signed Q2.14,
// identical but for last_copy, which marks the third. A zero determinant or a
// zero-length vector gives zero vectors with degenerate set.
// The first two vertices of a triangle are always taken. The third is taken as
// soon as the two-entry triangle queue has room.
// The copies of a triangle follow one a cycle while res is ready.
// The back end sets the pace: one shared 34 x 34 multiplier for 7 cross products
// (14 products) and 18 partial squares, then six 15-bit results found one bit at
// a time. It takes a new triangle only after the last copy of the one before.
// Reset empties the queue, returns the vertex count to the first vertex and
// idles the back end. When res stalls, the current copy holds; the front end
// goes on taking vertices, but a third one waits while the queue is full.
module triangle_tangent_bitangent (
	input  logic        clk,
	input  logic        arst_n,
	tanbt_vtx_if.sink   vtx,
	tanbt_res_if.source res
);
	import tanbt_pkg::*;

	logic push_valid;
	logic push_ready;
	tri_t push_data;
	logic pop_valid;
	logic pop_ready;
	tri_t pop_data;

	tanbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tanbt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tanbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res       (res)
	);

endmodule

// ----- rtl/tanbt_checker.sv -----
// Port-level checker for the tangent / bitangent unit, bound to the top level.
`include "triangle_tangent_bitangent_assert.svh"

module tanbt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic signed [tanbt_pkg::OUT_W-1:0] tangent_x,
	input logic signed [tanbt_pkg::OUT_W-1:0] tangent_y,
	input logic signed [tanbt_pkg::OUT_W-1:0] tangent_z,
	input logic signed [tanbt_pkg::OUT_W-1:0] bitangent_x,
	input logic signed [tanbt_pkg::OUT_W-1:0] bitangent_y,
	input logic signed [tanbt_pkg::OUT_W-1:0] bitangent_z,
	input logic                           degenerate,
	input logic                           last_copy
);
	import tanbt_pkg::*;

	localparam logic signed [OUT_W-1:0] UNIT_P = OUT_W'(UNIT);
	localparam logic signed [OUT_W-1:0] UNIT_N = -OUT_W'(UNIT);

	logic                   res_xfer;
	logic [NCOMP*OUT_W:0]   res_word;
	logic                   vecs_zero;
	logic                   x_in_range;

	assign res_xfer   = res_valid && res_ready;
	assign res_word   = {tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
		bitangent_z, degenerate};
	assign vecs_zero  = (res_word[NCOMP*OUT_W:1] == '0);
	assign x_in_range = tangent_x <= UNIT_P && tangent_x >= UNIT_N &&
		bitangent_x <= UNIT_P && bitangent_x >= UNIT_N;

	`TANBT_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	// the copies of one triangle follow without a gap and carry the same vectors
	`TANBT_ASSERT_NXT(a_copy_next, clk, arst_n, res_xfer && !last_copy, res_valid)
	`TANBT_ASSERT_NXT(a_copy_same, clk, arst_n, res_xfer && !last_copy, $stable(res_word))
	`TANBT_ASSERT_IMP(a_deg_zero, clk, arst_n, res_valid && degenerate, vecs_zero)
	`TANBT_ASSERT_IMP(a_unit_range, clk, arst_n, res_valid, x_in_range)

endmodule

bind triangle_tangent_bitangent tanbt_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.tangent_x   (res.tangent_x),
	.tangent_y   (res.tangent_y),
	.tangent_z   (res.tangent_z),
	.bitangent_x (res.bitangent_x),
	.bitangent_y (res.bitangent_y),
	.bitangent_z (res.bitangent_z),
	.degenerate  (res.degenerate),
	.last_copy   (res.last_copy)
);
